// ----- sv/rgb_rank_filter_by_lightness_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RGB rank filter
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_RANK_FILTER_BY_LIGHTNESS_ASSERT_SVH
`define RGB_RANK_FILTER_BY_LIGHTNESS_ASSERT_SVH

// same-cycle implication
`define RRFL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRFL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rrfl_pkg.sv -----
// ----------------------------------------------------------------------------
// rrfl_pkg
// Shared types, constants and helpers of the RGB rank filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrfl_pkg;

    localparam int MAX_RADIUS_DEF = 3;
    localparam int MAX_WIDTH_DEF  = 2048;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int LIGHT_W   = 10;
    localparam int ROW_W     = 12;
    localparam int COL_OUT_W = 11;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    // register map (word index)
    typedef enum logic [1:0] {
        REG_WINDOW_RADIUS = 2'd0,
        REG_RANK_KIND     = 2'd1,
        REG_LINE_WIDTH    = 2'd2
    } t_reg_idx;

    // rank selection codes
    typedef enum logic [1:0] {
        RANK_MIN    = 2'd0,
        RANK_MEDIAN = 2'd1,
        RANK_MAX    = 2'd2
    } t_rank;

    localparam logic [1:0]  RADIUS_RST = 2'd1;
    localparam logic [1:0]  RANK_RST   = 2'd1;
    localparam logic [11:0] WIDTH_RST  = 12'd640;

    function automatic logic [LIGHT_W-1:0] lightness(input logic [PIX_W-1:0] px);
        lightness = LIGHT_W'(px[7:0]) + LIGHT_W'(px[15:8]) + LIGHT_W'(px[23:16]);
    endfunction

endpackage

// ----- sv/rgb_rank_filter_by_lightness.sv -----
// ----------------------------------------------------------------------------
// rgb_rank_filter_by_lightness
// Rank-order filter over a square window of a raster RGB stream, ranked by
// lightness R+G+B, ties broken by raster order inside the window.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------
//  pixel in  | in        | i_valid / o_stall  | first_of_frame, blue/green/red
//  result out| out       | o_valid / i_stall  | out_blue/green/red, centre pos
//  config    | in        | APB psel/penable   | radius, rank, line width
//
//  One pixel beat is taken per cycle while o_stall is low. A beat that
//  completes a window has its result offered after five register steps (line
//  store read, window, compare, count, select), the first at the accepting edge.
//  The line stores are one bank per stored row; every bank is read and one
//  is written per beat, which sets the one-beat-per-cycle figure.
//  Stages advance independently, so bubbles fill while the output stalls.
//  Reset is synchronous active low; it clears counters, stage valids and
//  the registers to radius 1, median, 640 pixels. The line store is not
//  cleared: only rows already written are ever used. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rgb_rank_filter_by_lightness_assert.svh"

module rgb_rank_filter_by_lightness #(
    parameter int MAX_RADIUS = rrfl_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = rrfl_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rrfl_pkg::APB_AW-1:0]        paddr,
    input  logic [rrfl_pkg::APB_DW-1:0]        pwdata,
    output logic [rrfl_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    // pixel in
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_first_of_frame,
    input  logic [rrfl_pkg::CH_W-1:0]          i_blue,
    input  logic [rrfl_pkg::CH_W-1:0]          i_green,
    input  logic [rrfl_pkg::CH_W-1:0]          i_red,
    // result out
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [rrfl_pkg::CH_W-1:0]          o_out_blue,
    output logic [rrfl_pkg::CH_W-1:0]          o_out_green,
    output logic [rrfl_pkg::CH_W-1:0]          o_out_red,
    output logic [rrfl_pkg::ROW_W-1:0]         o_center_row,
    output logic [rrfl_pkg::COL_OUT_W-1:0]     o_center_col
);

    localparam int PIX_W    = rrfl_pkg::PIX_W;
    localparam int LIGHT_W  = rrfl_pkg::LIGHT_W;
    localparam int ROW_W    = rrfl_pkg::ROW_W;
    localparam int COLO_W   = rrfl_pkg::COL_OUT_W;
    localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
    localparam int SLOTS    = 2 * MAX_RADIUS;
    localparam int NW       = SIDE_MAX * SIDE_MAX;
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int SW       = $clog2(SLOTS);
    localparam int RW       = $clog2(MAX_RADIUS + 1);
    localparam int SDW      = $clog2(SIDE_MAX + 1);
    localparam int PW       = $clog2(NW);
    localparam int CNW      = $clog2(NW + 1);
    localparam int PGW      = $clog2(SIDE_MAX + 1);

    // ---------------------------------------------------------------- config
    logic [1:0]  r_window_radius;
    logic [1:0]  r_rank_kind;
    logic [11:0] r_line_width;
    logic        w_cfg_wr;
    rrfl_pkg::t_reg_idx w_reg;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg    = rrfl_pkg::t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (w_reg)
            rrfl_pkg::REG_WINDOW_RADIUS: prdata = 32'(r_window_radius);
            rrfl_pkg::REG_RANK_KIND:     prdata = 32'(r_rank_kind);
            rrfl_pkg::REG_LINE_WIDTH:    prdata = 32'(r_line_width);
            default:                     prdata = '0;
        endcase
    end

    // effective settings: zero width acts as one, clamp width and radius
    logic [CW:0]    w_width;
    logic [RW-1:0]  w_rad;
    logic [RW:0]    w_rad2;

    always_comb begin
        if (r_line_width == '0) begin
            w_width = (CW+1)'(1);
        end else if (32'(r_line_width) > MAX_WIDTH) begin
            w_width = (CW+1)'(MAX_WIDTH);
        end else begin
            w_width = (CW+1)'(r_line_width);
        end
        if (32'(r_window_radius) > MAX_RADIUS) begin
            w_rad = RW'(MAX_RADIUS);
        end else begin
            w_rad = RW'(r_window_radius);
        end
        w_rad2 = {w_rad, 1'b0};
    end

    // ---------------------------------------------------------------- handshake
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic r_prod1;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_adv1, w_acc;

    assign w_rdy5  = !r_v5 || !i_stall;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_adv1  = r_v1 && (!r_prod1 || w_rdy2);
    assign w_rdy1  = !r_v1 || !r_prod1 || w_rdy2;
    assign o_stall = !w_rdy1;
    assign w_acc   = i_valid && w_rdy1;
    assign o_valid = r_v5;

    // ---------------------------------------------------------------- position
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [SW-1:0]    r_slot;
    logic [CW-1:0]    w_col_base, w_col_cur;
    logic [ROW_W-1:0] w_row_cur;
    logic [SW-1:0]    w_slot_cur;
    logic             w_prod;
    logic             w_eol;
    logic [PIX_W-1:0] w_px;

    assign w_px = {i_red, i_green, i_blue};

    always_comb begin
        w_col_base = i_first_of_frame ? '0 : r_col;
        w_row_cur  = i_first_of_frame ? '0 : r_row;
        w_slot_cur = i_first_of_frame ? '0 : r_slot;
        // width lowered mid-row: column restarts at 0 at once, row and slot unchanged
        w_col_cur  = ({1'b0, w_col_base} >= w_width) ? '0 : w_col_base;
        w_eol      = ({1'b0, w_col_cur} + (CW+1)'(1)) >= w_width;
        w_prod     = (w_row_cur >= ROW_W'(w_rad2)) && (w_col_cur >= CW'(w_rad2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col           <= '0;
            r_row           <= '0;
            r_slot          <= '0;
            r_window_radius <= rrfl_pkg::RADIUS_RST;
            r_rank_kind     <= rrfl_pkg::RANK_RST;
            r_line_width    <= rrfl_pkg::WIDTH_RST;
        end else begin
            if (w_cfg_wr) begin
                unique case (w_reg)
                    rrfl_pkg::REG_WINDOW_RADIUS: r_window_radius <= pwdata[1:0];
                    rrfl_pkg::REG_RANK_KIND:     r_rank_kind     <= pwdata[1:0];
                    rrfl_pkg::REG_LINE_WIDTH:    r_line_width    <= pwdata[11:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                if (w_eol) begin
                    r_col <= '0;
                    if (w_row_cur < rrfl_pkg::ROW_MAX) begin
                        r_row  <= w_row_cur + ROW_W'(1);
                        r_slot <= (32'(w_slot_cur) == SLOTS - 1) ? '0
                                                                 : w_slot_cur + SW'(1);
                    end else begin
                        r_row  <= w_row_cur;
                        r_slot <= w_slot_cur;
                    end
                end else begin
                    r_col  <= w_col_cur + CW'(1);
                    r_row  <= w_row_cur;
                    r_slot <= w_slot_cur;
                end
            end
        end
    end

    // ---------------------------------------------------------------- line store
    // One bank per stored row; read-first so the bank being overwritten
    // still returns the row from SLOTS rows back.
    logic [PIX_W-1:0] r_bank_q [SLOTS];

    for (genvar b = 0; b < SLOTS; b++) begin : g_bank
        logic [PIX_W-1:0] r_mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (w_acc) begin
                r_bank_q[b] <= r_mem[w_col_cur];
                if (32'(w_slot_cur) == b) begin
                    r_mem[w_col_cur] <= w_px;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 1
    logic [PIX_W-1:0]  r_px1;
    logic [SW-1:0]     r_slot1;
    logic [ROW_W-1:0]  r_crow1;
    logic [COLO_W-1:0] r_ccol1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
        if (w_acc) begin
            r_px1   <= w_px;
            r_prod1 <= w_prod;
            r_slot1 <= w_slot_cur;
            r_crow1 <= w_row_cur - ROW_W'(w_rad);
            r_ccol1 <= COLO_W'(w_col_cur - CW'(w_rad));
        end
    end

    // ---------------------------------------------------------------- window
    logic [PIX_W-1:0]   r_win  [NW];
    logic [LIGHT_W-1:0] r_lwin [NW];
    logic [PIX_W-1:0]   n_win  [NW];
    logic [LIGHT_W-1:0] n_lwin [NW];
    logic [PIX_W-1:0]   w_load [SIDE_MAX];
    logic [SW:0]        w_bidx [SLOTS];

    // window row dy takes the bank dy rows after the current one (mod SLOTS)
    always_comb begin
        for (int dy = 0; dy < SLOTS; dy++) begin
            w_bidx[dy] = {1'b0, r_slot1} + (SW+1)'(dy);
            if (32'(w_bidx[dy]) >= SLOTS) begin
                w_bidx[dy] = w_bidx[dy] - (SW+1)'(SLOTS);
            end
            w_load[dy] = r_bank_q[SW'(w_bidx[dy])];
        end
        w_load[SIDE_MAX-1] = r_px1;
        for (int dy = 0; dy < SIDE_MAX; dy++) begin
            for (int dx = 0; dx < SIDE_MAX; dx++) begin
                if (dx < SIDE_MAX - 1) begin
                    n_win[dy*SIDE_MAX+dx]  = r_win[dy*SIDE_MAX+dx+1];
                    n_lwin[dy*SIDE_MAX+dx] = r_lwin[dy*SIDE_MAX+dx+1];
                end else begin
                    n_win[dy*SIDE_MAX+dx]  = w_load[dy];
                    n_lwin[dy*SIDE_MAX+dx] = rrfl_pkg::lightness(w_load[dy]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_win  <= n_win;
            r_lwin <= n_lwin;
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic [SDW-1:0] w_side, w_first;
    logic [CNW-1:0] w_count;
    logic [PW-1:0]  w_tgt;
    logic [NW-1:0]  w_incl;

    always_comb begin
        w_side  = SDW'({w_rad, 1'b1});
        w_first = SDW'(SIDE_MAX) - w_side;
        w_count = CNW'(w_side) * CNW'(w_side);
        unique case (rrfl_pkg::t_rank'(r_rank_kind))
            rrfl_pkg::RANK_MEDIAN: w_tgt = PW'(w_count >> 1);
            rrfl_pkg::RANK_MAX:    w_tgt = PW'(w_count - CNW'(1));
            default:               w_tgt = '0;
        endcase
        for (int dy = 0; dy < SIDE_MAX; dy++) begin
            for (int dx = 0; dx < SIDE_MAX; dx++) begin
                w_incl[dy*SIDE_MAX+dx] = (SDW'(dy) >= w_first) && (SDW'(dx) >= w_first);
            end
        end
    end

    logic [PIX_W-1:0]   r_pix2 [NW];
    logic [LIGHT_W-1:0] r_lt2  [NW];
    logic [NW-1:0]      r_incl2;
    logic [PW-1:0]      r_tgt2;
    logic [ROW_W-1:0]   r_crow2;
    logic [COLO_W-1:0]  r_ccol2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= w_adv1 && r_prod1;
        end
        if (w_adv1 && r_prod1) begin
            r_pix2  <= n_win;
            r_lt2   <= n_lwin;
            r_incl2 <= w_incl;
            r_tgt2  <= w_tgt;
            r_crow2 <= r_crow1;
            r_ccol2 <= r_ccol1;
        end
    end

    // ---------------------------------------------------------------- stage 3
    // per element, count lower-ranked members of each window row
    logic [PGW-1:0] w_part [NW][SIDE_MAX];

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            for (int g = 0; g < SIDE_MAX; g++) begin
                w_part[i][g] = '0;
                for (int dx = 0; dx < SIDE_MAX; dx++) begin
                    if (r_incl2[g*SIDE_MAX+dx] &&
                        ((r_lt2[g*SIDE_MAX+dx] < r_lt2[i]) ||
                         ((r_lt2[g*SIDE_MAX+dx] == r_lt2[i]) && (g*SIDE_MAX+dx < i)))) begin
                        w_part[i][g] = w_part[i][g] + PGW'(1);
                    end
                end
            end
        end
    end

    logic [PGW-1:0]    r_part3 [NW][SIDE_MAX];
    logic [PIX_W-1:0]  r_pix3  [NW];
    logic [NW-1:0]     r_incl3;
    logic [PW-1:0]     r_tgt3;
    logic [ROW_W-1:0]  r_crow3;
    logic [COLO_W-1:0] r_ccol3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
        if (w_rdy3 && r_v2) begin
            r_part3 <= w_part;
            r_pix3  <= r_pix2;
            r_incl3 <= r_incl2;
            r_tgt3  <= r_tgt2;
            r_crow3 <= r_crow2;
            r_ccol3 <= r_ccol2;
        end
    end

    // ---------------------------------------------------------------- stage 4
    logic [PW-1:0] w_pos [NW];

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            w_pos[i] = '0;
            for (int g = 0; g < SIDE_MAX; g++) begin
                w_pos[i] = w_pos[i] + PW'(r_part3[i][g]);
            end
        end
    end

    logic [PW-1:0]     r_pos4 [NW];
    logic [PIX_W-1:0]  r_pix4 [NW];
    logic [NW-1:0]     r_incl4;
    logic [PW-1:0]     r_tgt4;
    logic [ROW_W-1:0]  r_crow4;
    logic [COLO_W-1:0] r_ccol4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= r_v3;
        end
        if (w_rdy4 && r_v3) begin
            r_pos4  <= w_pos;
            r_pix4  <= r_pix3;
            r_incl4 <= r_incl3;
            r_tgt4  <= r_tgt3;
            r_crow4 <= r_crow3;
            r_ccol4 <= r_ccol3;
        end
    end

    // ---------------------------------------------------------------- stage 5
    // positions are a permutation, so exactly one member hits the target
    logic [NW-1:0]    w_match;
    logic [PIX_W-1:0] w_sel;

    always_comb begin
        w_sel = '0;
        for (int i = 0; i < NW; i++) begin
            w_match[i] = r_incl4[i] && (r_pos4[i] == r_tgt4);
            w_sel      = w_sel | (r_pix4[i] & {PIX_W{w_match[i]}});
        end
    end

    logic [PIX_W-1:0] r_out_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_rdy5) begin
            r_v5 <= r_v4;
        end
        if (w_rdy5 && r_v4) begin
            r_out_px     <= w_sel;
            o_center_row <= r_crow4;
            o_center_col <= r_ccol4;
        end
    end

    assign o_out_blue  = r_out_px[7:0];
    assign o_out_green = r_out_px[15:8];
    assign o_out_red   = r_out_px[23:16];

    // ---------------------------------------------------------------- checks
    `RRFL_ASSERT_IMP(a_single_rank, r_v4, $onehot(w_match), "rank select not one-hot")
    `RRFL_ASSERT_IMP(a_slot_range, 1'b1, 32'(r_slot) < SLOTS, "row slot out of range")
    `RRFL_ASSERT_NXT(a_accept_loads, w_acc, r_v1, "accepted beat lost at stage 1")
    `RRFL_ASSERT_IMP(a_centre_incl, r_v2, r_incl2[NW-1], "window corner not included")

endmodule
